// ===== rtl/ctaus_pkg.sv =====
// Package for the combined Tausworthe generator: field widths, codes, reset values,
// and the component recurrence and seeding functions.
// No dependencies; used by ctaus_ctrl, ctaus_dp and combined_tausworthe_rng_top.
package ctaus_pkg;

   localparam int WORD_W       = 32;
   localparam int VALUE_W      = 64;
   localparam int REQ_DATA_W   = 40;
   localparam int WARMUP_STEPS = 6;
   localparam int WARM_CNT_W   = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;

   localparam logic [WORD_W-1:0] LCG_MULT         = 32'd69069;
   localparam logic [WORD_W-1:0] COMP_ONE_RESET   = 32'd69069;
   localparam logic [WORD_W-1:0] COMP_TWO_RESET   = 32'd475559465;
   localparam logic [WORD_W-1:0] COMP_THREE_RESET = 32'd2801775573;
   localparam logic [WORD_W-1:0] COMP_ONE_MIN     = 32'd2;
   localparam logic [WORD_W-1:0] COMP_TWO_MIN     = 32'd8;
   localparam logic [WORD_W-1:0] COMP_THREE_MIN   = 32'd16;
   localparam logic [WORD_W-1:0] COMP_ONE_KEEP    = 32'hFFFF_FFFE;
   localparam logic [WORD_W-1:0] COMP_TWO_KEEP    = 32'hFFFF_FFF8;
   localparam logic [WORD_W-1:0] COMP_THREE_KEEP  = 32'hFFFF_FFF0;

   typedef enum logic {
      OP_DRAW,
      OP_RESEED
   } op_type;

   typedef enum logic [1:0] {
      WIDTH_8,
      WIDTH_16,
      WIDTH_32,
      WIDTH_64
   } width_type;

   typedef enum logic [1:0] {
      LCG_NONE,
      LCG_ONE,
      LCG_TWO,
      LCG_THREE
   } lcg_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED_ONE,
      ST_SEED_TWO,
      ST_SEED_THREE,
      ST_WARM,
      ST_DRAW_HI,
      ST_DRAW_LO
   } state_type;

   typedef struct packed {
      logic        load_req;
      lcg_sel_type lcg_sel;
      logic        step;
      logic        save_hi;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [WORD_W-1:0] lcg(input logic [WORD_W-1:0] n);
      lcg = n * LCG_MULT;
   endfunction

   function automatic logic [WORD_W-1:0] raise_min(input logic [WORD_W-1:0] v,
                                                   input logic [WORD_W-1:0] lo);
      raise_min = (v < lo) ? v + lo : v;
   endfunction

   function automatic logic [WORD_W-1:0] taus_one(input logic [WORD_W-1:0] s);
      taus_one = ((s & COMP_ONE_KEEP) << 12) ^ (((s << 13) ^ s) >> 19);
   endfunction

   function automatic logic [WORD_W-1:0] taus_two(input logic [WORD_W-1:0] s);
      taus_two = ((s & COMP_TWO_KEEP) << 4) ^ (((s << 2) ^ s) >> 25);
   endfunction

   function automatic logic [WORD_W-1:0] taus_three(input logic [WORD_W-1:0] s);
      taus_three = ((s & COMP_THREE_KEEP) << 17) ^ (((s << 3) ^ s) >> 11);
   endfunction

endpackage

// ===== rtl/ctaus_ctrl.sv =====
// Controller state machine for the combined Tausworthe generator.
// Sequences reseed, warm-up and draw steps; depends on ctaus_pkg.
module ctaus_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_op,
   input  logic [1:0]            req_width,
   input  ctaus_pkg::status_type status,
   output ctaus_pkg::cmd_type    cmd
);

   ctaus_pkg::state_type                  state_ff, state_in;
   logic [ctaus_pkg::WARM_CNT_W-1:0]      warm_cnt_ff, warm_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ctaus_pkg::ST_IDLE;
         warm_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         warm_cnt_ff <= warm_cnt_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      warm_cnt_in  = warm_cnt_ff;
      req_tready   = 1'b0;
      cmd.load_req = 1'b0;
      cmd.lcg_sel  = ctaus_pkg::LCG_NONE;
      cmd.step     = 1'b0;
      cmd.save_hi  = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         ctaus_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               if (ctaus_pkg::op_type'(req_op) == ctaus_pkg::OP_RESEED) begin
                  state_in = ctaus_pkg::ST_SEED_ONE;
               end else if (ctaus_pkg::width_type'(req_width) == ctaus_pkg::WIDTH_64) begin
                  state_in = ctaus_pkg::ST_DRAW_HI;
               end else begin
                  state_in = ctaus_pkg::ST_DRAW_LO;
               end
            end
         end
         ctaus_pkg::ST_SEED_ONE: begin
            cmd.lcg_sel = ctaus_pkg::LCG_ONE;
            state_in    = ctaus_pkg::ST_SEED_TWO;
         end
         ctaus_pkg::ST_SEED_TWO: begin
            cmd.lcg_sel = ctaus_pkg::LCG_TWO;
            state_in    = ctaus_pkg::ST_SEED_THREE;
         end
         ctaus_pkg::ST_SEED_THREE: begin
            cmd.lcg_sel = ctaus_pkg::LCG_THREE;
            warm_cnt_in = '0;
            state_in    = (ctaus_pkg::WARMUP_STEPS == 0) ? ctaus_pkg::ST_IDLE
                                                         : ctaus_pkg::ST_WARM;
         end
         ctaus_pkg::ST_WARM: begin
            cmd.step    = 1'b1;
            warm_cnt_in = warm_cnt_ff + 1'b1;
            if (warm_cnt_ff == ctaus_pkg::WARM_CNT_W'(ctaus_pkg::WARMUP_STEPS - 1)) begin
               state_in = ctaus_pkg::ST_IDLE;
            end
         end
         ctaus_pkg::ST_DRAW_HI: begin
            cmd.step    = 1'b1;
            cmd.save_hi = 1'b1;
            state_in    = ctaus_pkg::ST_DRAW_LO;
         end
         ctaus_pkg::ST_DRAW_LO: begin
            if (status.out_free) begin
               cmd.step     = 1'b1;
               cmd.load_out = 1'b1;
               state_in     = ctaus_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctaus_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/ctaus_dp.sv =====
// Datapath for the combined Tausworthe generator: component registers, shared
// seeding multiplier, step logic and output register. Depends on ctaus_pkg.
module ctaus_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ctaus_pkg::cmd_type                   cmd,
   output ctaus_pkg::status_type                status,
   input  logic [ctaus_pkg::WORD_W-1:0]         req_seed,
   input  logic [1:0]                           req_width,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ctaus_pkg::VALUE_W-1:0]        rsp_tdata
);

   logic [ctaus_pkg::WORD_W-1:0]  comp_one_ff, comp_one_in;
   logic [ctaus_pkg::WORD_W-1:0]  comp_two_ff, comp_two_in;
   logic [ctaus_pkg::WORD_W-1:0]  comp_three_ff, comp_three_in;
   logic [ctaus_pkg::WORD_W-1:0]  seed_ff;
   ctaus_pkg::width_type          width_ff;
   logic [ctaus_pkg::WORD_W-1:0]  hi_ff;
   logic [ctaus_pkg::VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ctaus_pkg::WORD_W-1:0]  lcg_operand;
   logic [ctaus_pkg::WORD_W-1:0]  lcg_min;
   logic [ctaus_pkg::WORD_W-1:0]  lcg_value;
   logic [ctaus_pkg::WORD_W-1:0]  next_one, next_two, next_three;
   logic [ctaus_pkg::WORD_W-1:0]  step_word;

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   assign next_one   = ctaus_pkg::taus_one(comp_one_ff);
   assign next_two   = ctaus_pkg::taus_two(comp_two_ff);
   assign next_three = ctaus_pkg::taus_three(comp_three_ff);
   assign step_word  = next_one ^ next_two ^ next_three;

   // One multiplier serves all three seeding passes.
   always_comb begin
      case (cmd.lcg_sel)
         ctaus_pkg::LCG_TWO: begin
            lcg_operand = comp_one_ff;
            lcg_min     = ctaus_pkg::COMP_TWO_MIN;
         end
         ctaus_pkg::LCG_THREE: begin
            lcg_operand = comp_two_ff;
            lcg_min     = ctaus_pkg::COMP_THREE_MIN;
         end
         default: begin
            lcg_operand = seed_ff;
            lcg_min     = ctaus_pkg::COMP_ONE_MIN;
         end
      endcase
      lcg_value = ctaus_pkg::raise_min(ctaus_pkg::lcg(lcg_operand), lcg_min);
   end

   always_comb begin
      comp_one_in   = comp_one_ff;
      comp_two_in   = comp_two_ff;
      comp_three_in = comp_three_ff;
      if (cmd.step) begin
         comp_one_in   = next_one;
         comp_two_in   = next_two;
         comp_three_in = next_three;
      end else begin
         case (cmd.lcg_sel)
            ctaus_pkg::LCG_ONE:   comp_one_in   = lcg_value;
            ctaus_pkg::LCG_TWO:   comp_two_in   = lcg_value;
            ctaus_pkg::LCG_THREE: comp_three_in = lcg_value;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (width_ff)
         ctaus_pkg::WIDTH_8:  rsp_data_in = {56'd0, step_word[7:0]};
         ctaus_pkg::WIDTH_16: rsp_data_in = {48'd0, step_word[15:0]};
         ctaus_pkg::WIDTH_32: rsp_data_in = {32'd0, step_word};
         default:             rsp_data_in = {hi_ff, step_word};
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_one_ff   <= ctaus_pkg::COMP_ONE_RESET;
         comp_two_ff   <= ctaus_pkg::COMP_TWO_RESET;
         comp_three_ff <= ctaus_pkg::COMP_THREE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         comp_one_ff   <= comp_one_in;
         comp_two_ff   <= comp_two_in;
         comp_three_ff <= comp_three_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         seed_ff  <= req_seed;
         width_ff <= ctaus_pkg::width_type'(req_width);
      end
      if (cmd.save_hi) begin
         hi_ff <= step_word;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_load_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("Result loaded while the output register was still occupied.");

   a_hi_only_wide: assert property (@(posedge clock) disable iff (reset)
      cmd.save_hi |-> (width_ff == ctaus_pkg::WIDTH_64))
      else $error("High half saved for a draw narrower than 64 bits.");

   a_step_lcg_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (cmd.lcg_sel == ctaus_pkg::LCG_NONE))
      else $error("Step and seeding pass requested in the same cycle.");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(cmd.load_out))
      else $error("Result beat appeared without a load.");
`endif

endmodule

// ===== rtl/combined_tausworthe_rng_top.sv =====
// Combined three-component Tausworthe generator with 32-bit components.
// A draw of 8, 16 or 32 bits passes through the accept state and one step of the
// recurrence unit (ST_DRAW_LO, which waits for a free output register); a 64-bit draw
// steps once per half, in ST_DRAW_HI and then ST_DRAW_LO. A reseed makes three
// passes through the single seeding multiplier, then WARMUP_STEPS warm-up steps, one a
// cycle, and returns no result. The block takes one request at a time; results sit in an
// output register, so the next request is taken while an earlier result waits.
// Top level; depends on ctaus_pkg, ctaus_ctrl and ctaus_dp.
module combined_tausworthe_rng_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [ctaus_pkg::REQ_DATA_W-1:0]      req_tdata,   // seed[31:0], out_width[33:32]
   input  logic                                  req_tuser,   // op[0]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [ctaus_pkg::VALUE_W-1:0]         rsp_tdata    // value[63:0]
);

   ctaus_pkg::cmd_type    cmd;
   ctaus_pkg::status_type status;

   ctaus_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_width  (req_tdata[33:32]),
      .status     (status),
      .cmd        (cmd)
   );

   ctaus_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_seed   (req_tdata[31:0]),
      .req_width  (req_tdata[33:32]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
